[src/assert_macros.svh]
// Assertion macros used by the checker file.
// Needs clk and rst_n in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, off while reset is held.
`define TFN_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Implication form of the above.
`define TFN_ASSERT_IMP(lbl, pre, post, msg) \
  `TFN_ASSERT(lbl, (pre) |-> (post), msg)

`endif

[src/tfn_pkg.sv]
// Package for the triangle face normal block: widths, defaults, queue entry.
// No dependencies.
package tfn_pkg;

  localparam int NORM_FRAC_DEF = 14;
  localparam int CRD_W         = 32;
  localparam int EDGE_W        = 33;
  localparam int PROD_W        = 66;
  localparam int CROSS_W       = 68;
  localparam int MAG_W         = 67;
  localparam int RED_W         = 31;
  localparam int SHIFT_W       = 7;
  localparam int NRM_W         = 16;
  localparam int QUEUE_DEPTH   = 4;
  localparam int QPTR_W        = 2;
  localparam int QCNT_W        = 3;

  // one transfer from the front end to the back end
  typedef struct packed {
    logic [2:0][RED_W-1:0] mag;
    logic [2:0]            neg;
    logic                  degen;
  } qent_t;

endpackage

[src/tfn_front.sv]
// Front end: edges, exact cross product, sign/magnitude and range reduction.
// Depends on tfn_pkg.
module tfn_front import tfn_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic signed [CRD_W-1:0] in_ax,
  input  logic signed [CRD_W-1:0] in_ay,
  input  logic signed [CRD_W-1:0] in_az,
  input  logic signed [CRD_W-1:0] in_bx,
  input  logic signed [CRD_W-1:0] in_by,
  input  logic signed [CRD_W-1:0] in_bz,
  input  logic signed [CRD_W-1:0] in_cx,
  input  logic signed [CRD_W-1:0] in_cy,
  input  logic signed [CRD_W-1:0] in_cz,
  output logic                    f_valid,
  input  logic                    f_full,
  output qent_t                   f_data
);

  logic v1_r, v2_r, v3_r, v4_r, v5_r;
  logic rdy1, rdy2, rdy3, rdy4, rdy5;

  logic signed [EDGE_W-1:0] e1_r [0:2];
  logic signed [EDGE_W-1:0] e2_r [0:2];
  logic signed [PROD_W-1:0] p_r  [0:5];
  logic [MAG_W-1:0]         mag3_r [0:2];
  logic [2:0]               neg3_r;
  logic [MAG_W-1:0]         mag4_r [0:2];
  logic [2:0]               neg4_r;
  logic                     degen4_r;
  logic [SHIFT_W-1:0]       sh4_r;
  qent_t                    out_r;

  logic signed [CROSS_W-1:0] n_nxt [0:2];
  logic [MAG_W-1:0]          all_or;
  logic [SHIFT_W-1:0]        blen;
  logic [SHIFT_W-1:0]        sh_nxt;

  assign rdy5     = !v5_r || !f_full;
  assign rdy4     = !v4_r || rdy5;
  assign rdy3     = !v3_r || rdy4;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign in_stall = !rdy1;
  assign f_valid  = v5_r;
  assign f_data   = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
      if (rdy5) v5_r <= v4_r;
    end
  end

  // edges: e1 = c - b, e2 = b - a
  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) begin
      e1_r[0] <= EDGE_W'(in_cx) - EDGE_W'(in_bx);
      e1_r[1] <= EDGE_W'(in_cy) - EDGE_W'(in_by);
      e1_r[2] <= EDGE_W'(in_cz) - EDGE_W'(in_bz);
      e2_r[0] <= EDGE_W'(in_bx) - EDGE_W'(in_ax);
      e2_r[1] <= EDGE_W'(in_by) - EDGE_W'(in_ay);
      e2_r[2] <= EDGE_W'(in_bz) - EDGE_W'(in_az);
    end
  end

  // six partial products of e1 x e2
  always_ff @(posedge clk) begin
    if (rdy2 && v1_r) begin
      p_r[0] <= PROD_W'(e1_r[1]) * PROD_W'(e2_r[2]);
      p_r[1] <= PROD_W'(e1_r[2]) * PROD_W'(e2_r[1]);
      p_r[2] <= PROD_W'(e1_r[2]) * PROD_W'(e2_r[0]);
      p_r[3] <= PROD_W'(e1_r[0]) * PROD_W'(e2_r[2]);
      p_r[4] <= PROD_W'(e1_r[0]) * PROD_W'(e2_r[1]);
      p_r[5] <= PROD_W'(e1_r[1]) * PROD_W'(e2_r[0]);
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      n_nxt[i] = CROSS_W'(p_r[2*i]) - CROSS_W'(p_r[2*i+1]);
    end
  end

  always_ff @(posedge clk) begin
    if (rdy3 && v2_r) begin
      for (int i = 0; i < 3; i++) begin
        neg3_r[i] <= n_nxt[i][CROSS_W-1];
        mag3_r[i] <= n_nxt[i][CROSS_W-1] ? MAG_W'(-n_nxt[i]) : MAG_W'(n_nxt[i]);
      end
    end
  end

  // bit length of the largest magnitude equals that of the OR of all three
  always_comb begin
    all_or = mag3_r[0] | mag3_r[1] | mag3_r[2];
    blen   = '0;
    for (int j = 0; j < MAG_W; j++) begin
      if (all_or[j]) blen = SHIFT_W'(j + 1);
    end
    sh_nxt = (blen > SHIFT_W'(RED_W)) ? blen - SHIFT_W'(RED_W) : '0;
  end

  always_ff @(posedge clk) begin
    if (rdy4 && v3_r) begin
      mag4_r   <= mag3_r;
      neg4_r   <= neg3_r;
      degen4_r <= (all_or == '0);
      sh4_r    <= sh_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy5 && v4_r) begin
      for (int i = 0; i < 3; i++) begin
        out_r.mag[i] <= RED_W'(mag4_r[i] >> sh4_r);
      end
      out_r.neg   <= neg4_r;
      out_r.degen <= degen4_r;
    end
  end

endmodule

[src/tfn_queue.sv]
// Small FIFO between the front and back ends.
// Depends on tfn_pkg.
module tfn_queue import tfn_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  qent_t push_data,
  output logic  full,
  input  logic  pop,
  output logic  nonempty,
  output qent_t pop_data
);

  qent_t              mem_r [0:QUEUE_DEPTH-1];
  logic [QPTR_W-1:0]  wp_r, rp_r;
  logic [QCNT_W-1:0]  cnt_r;
  logic               do_push, do_pop;

  assign full     = (cnt_r == QCNT_W'(QUEUE_DEPTH));
  assign nonempty = (cnt_r != '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && nonempty;
  assign pop_data = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) wp_r <= wp_r + 1'b1;
      if (do_pop)  rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + QCNT_W'(do_push) - QCNT_W'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wp_r] <= push_data;
  end

endmodule

[src/tfn_back.sv]
// Back end: sum of squares, digit-per-stage root-ratio, rounding and output reg.
// Depends on tfn_pkg.
module tfn_back import tfn_pkg::*; #(
  parameter int NORMAL_FRAC_BITS = NORM_FRAC_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    q_valid,
  input  qent_t                   q_data,
  output logic                    q_pop,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [NRM_W-1:0] out_nx,
  output logic signed [NRM_W-1:0] out_ny,
  output logic signed [NRM_W-1:0] out_nz,
  output logic                    out_degenerate
);

  localparam int TOP = (NORMAL_FRAC_BITS + 1 > 31) ? 31 : NORMAL_FRAC_BITS + 1;
  localparam int NIT = TOP + 1;
  localparam int WR  = TOP + 1;
  localparam int WD  = 2 * TOP + 68;
  localparam int WP  = TOP + 66;
  localparam int SQ_W = 2 * RED_W;
  localparam int SUM_W = 64;
  localparam logic [WR-1:0] SAT = WR'(32767);

  logic                v_sq_r;
  logic [SQ_W-1:0]     msq_r [0:2];
  logic [2:0]          neg_sq_r;
  logic                degen_sq_r;
  logic                rdy_sq;
  logic                rdy_out;

  logic                v_it_r   [0:NIT];
  logic                rdy_it   [0:NIT];
  logic [WD-1:0]       d_r      [0:NIT][0:2];
  logic [WP-1:0]       p_r      [0:NIT][0:2];
  logic [WR-1:0]       r_r      [0:NIT][0:2];
  logic [SUM_W-1:0]    s_r      [0:NIT];
  logic [2:0]          neg_it_r [0:NIT];
  logic                degen_it_r [0:NIT];

  logic                    ov_r;
  logic signed [NRM_W-1:0] onx_r, ony_r, onz_r;
  logic                    odeg_r;
  logic [NRM_W-1:0]        q_fin [0:2];

  assign rdy_out     = !ov_r || !out_stall;
  assign rdy_it[NIT] = !v_it_r[NIT] || rdy_out;
  assign rdy_sq      = !v_sq_r || rdy_it[0];
  assign q_pop       = q_valid && rdy_sq;

  // squares of the reduced magnitudes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_sq_r <= 1'b0;
    end else if (rdy_sq) begin
      v_sq_r <= q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      for (int i = 0; i < 3; i++) begin
        msq_r[i] <= SQ_W'(q_data.mag[i]) * SQ_W'(q_data.mag[i]);
      end
      neg_sq_r   <= q_data.neg;
      degen_sq_r <= q_data.degen;
    end
  end

  // S and the scaled targets m^2 << (2F+2)
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_it_r[0] <= 1'b0;
    end else if (rdy_it[0]) begin
      v_it_r[0] <= v_sq_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_it[0] && v_sq_r) begin
      s_r[0] <= SUM_W'(msq_r[0]) + SUM_W'(msq_r[1]) + SUM_W'(msq_r[2]);
      for (int i = 0; i < 3; i++) begin
        d_r[0][i] <= WD'(msq_r[i]) << (2 * NORMAL_FRAC_BITS + 2);
        p_r[0][i] <= '0;
        r_r[0][i] <= '0;
      end
      neg_it_r[0]   <= neg_sq_r;
      degen_it_r[0] <= degen_sq_r;
    end
  end

  // one result bit per stage: keep D = target - r^2*S and P = r*S
  for (genvar k = 0; k < NIT; k++) begin : g_it
    localparam int B = TOP - k;
    logic [WD-1:0] cmp  [0:2];
    logic          take [0:2];

    assign rdy_it[k] = !v_it_r[k] || rdy_it[k+1];

    always_comb begin
      for (int i = 0; i < 3; i++) begin
        cmp[i]  = (WD'(p_r[k][i]) << (B + 1)) + (WD'(s_r[k]) << (2 * B));
        take[i] = (d_r[k][i] >= cmp[i]);
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_it_r[k+1] <= 1'b0;
      end else if (rdy_it[k+1]) begin
        v_it_r[k+1] <= v_it_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (rdy_it[k+1] && v_it_r[k]) begin
        for (int i = 0; i < 3; i++) begin
          if (take[i]) begin
            d_r[k+1][i] <= d_r[k][i] - cmp[i];
            p_r[k+1][i] <= p_r[k][i] + (WP'(s_r[k]) << B);
            r_r[k+1][i] <= r_r[k][i] | (WR'(1) << B);
          end else begin
            d_r[k+1][i] <= d_r[k][i];
            p_r[k+1][i] <= p_r[k][i];
            r_r[k+1][i] <= r_r[k][i];
          end
        end
        s_r[k+1]        <= s_r[k];
        neg_it_r[k+1]   <= neg_it_r[k];
        degen_it_r[k+1] <= degen_it_r[k];
      end
    end
  end

  // round half away, saturate, apply sign
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      logic [WR:0]  rq;
      logic [WR-1:0] qm;
      rq = ({1'b0, r_r[NIT][i]} + 1'b1) >> 1;
      qm = WR'(rq);
      if (qm > SAT) qm = SAT;
      q_fin[i] = neg_it_r[NIT][i] ? NRM_W'(-qm) : NRM_W'(qm);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (rdy_out) begin
      ov_r <= v_it_r[NIT];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_out && v_it_r[NIT]) begin
      odeg_r <= degen_it_r[NIT];
      onx_r  <= degen_it_r[NIT] ? '0 : $signed(q_fin[0]);
      ony_r  <= degen_it_r[NIT] ? '0 : $signed(q_fin[1]);
      onz_r  <= degen_it_r[NIT] ? '0 : $signed(q_fin[2]);
    end
  end

  assign out_valid      = ov_r;
  assign out_nx         = onx_r;
  assign out_ny         = ony_r;
  assign out_nz         = onz_r;
  assign out_degenerate = odeg_r;

endmodule

[src/triangle_face_normal.sv]
// Output format: Q2.14 at the default NORMAL_FRAC_BITS of 14.
// Throughput: one triangle per cycle while no stall holds the flow, set by the fully pipelined front end and
//   the one-bit-per-stage root-ratio pipeline of the back end.
// Reset: synchronous, active low; clears all valid flags and the queue pointers.
// Front end, 4-entry queue and back end stall independently.
// Depends on tfn_pkg, tfn_front, tfn_queue, tfn_back.
module triangle_face_normal import tfn_pkg::*; #(
  parameter int NORMAL_FRAC_BITS = NORM_FRAC_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  // input channel: one transfer is one triangle
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic signed [CRD_W-1:0] in_ax,
  input  logic signed [CRD_W-1:0] in_ay,
  input  logic signed [CRD_W-1:0] in_az,
  input  logic signed [CRD_W-1:0] in_bx,
  input  logic signed [CRD_W-1:0] in_by,
  input  logic signed [CRD_W-1:0] in_bz,
  input  logic signed [CRD_W-1:0] in_cx,
  input  logic signed [CRD_W-1:0] in_cy,
  input  logic signed [CRD_W-1:0] in_cz,
  // result channel: one transfer is one unit normal
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [NRM_W-1:0] out_nx,
  output logic signed [NRM_W-1:0] out_ny,
  output logic signed [NRM_W-1:0] out_nz,
  output logic                    out_degenerate
);

  logic  f_valid, f_full;
  qent_t f_data;
  logic  q_nonempty, q_pop;
  qent_t q_data;

  // edges, cross product, magnitude normalization to 31 bits
  tfn_front u_front (
    .clk, .rst_n,
    .in_valid, .in_stall,
    .in_ax, .in_ay, .in_az, .in_bx, .in_by, .in_bz, .in_cx, .in_cy, .in_cz,
    .f_valid, .f_full, .f_data
  );

  // decouples front-end transfers from back-end stalls
  tfn_queue u_queue (
    .clk, .rst_n,
    .push(f_valid), .push_data(f_data), .full(f_full),
    .pop(q_pop), .nonempty(q_nonempty), .pop_data(q_data)
  );

  // round(m * 2^F / sqrt(S)) per component, then sign and saturation
  tfn_back #(.NORMAL_FRAC_BITS(NORMAL_FRAC_BITS)) u_back (
    .clk, .rst_n,
    .q_valid(q_nonempty), .q_data, .q_pop,
    .out_valid, .out_stall, .out_nx, .out_ny, .out_nz, .out_degenerate
  );

endmodule

[src/tfn_checker.sv]
// Port-level checks for triangle_face_normal, bound to the top level.
// Depends on tfn_pkg and assert_macros.svh.
`include "assert_macros.svh"
module tfn_checker import tfn_pkg::*; (
  input logic                    clk,
  input logic                    rst_n,
  input logic                    out_valid,
  input logic                    out_stall,
  input logic signed [NRM_W-1:0] out_nx,
  input logic signed [NRM_W-1:0] out_ny,
  input logic signed [NRM_W-1:0] out_nz,
  input logic                    out_degenerate
);

  `TFN_ASSERT_IMP(a_out_hold, out_valid && out_stall, ##1 out_valid, "result dropped under stall")
  `TFN_ASSERT_IMP(a_degen_zero, out_valid && out_degenerate, out_nx == 0 && out_ny == 0 && out_nz == 0, "degenerate result not zero")
  `TFN_ASSERT_IMP(a_no_min, out_valid, out_nx != -32768 && out_ny != -32768 && out_nz != -32768, "asymmetric saturation")
  `TFN_ASSERT_IMP(a_nonzero, out_valid && !out_degenerate, out_nx != 0 || out_ny != 0 || out_nz != 0, "zero normal without degenerate flag")

endmodule

bind triangle_face_normal tfn_checker u_tfn_checker (.*);

[tb/sv/tb.sv]
`timescale 1ns / 1ps
// Testbench for triangle_face_normal: drives triangles, predicts each unit
// normal with an exact integer model and checks every result. Needs tfn_pkg.
module tb;
  import tfn_pkg::*;

  localparam int NFB = NORM_FRAC_DEF;   // normal fraction bits of the instance
  localparam int LAT = 8 + NFB + 2 + 10;  // pipeline depth plus margin

  // one triangle; vertex a, b, c, components x, y, z
  typedef struct {
    logic signed [CRD_W-1:0] a [3];
    logic signed [CRD_W-1:0] b [3];
    logic signed [CRD_W-1:0] c [3];
  } tri_t;

  // one unit normal
  typedef struct {
    logic signed [NRM_W-1:0] n [3];
    logic                    degen;
  } normal_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [CRD_W-1:0] in_ax = '0, in_ay = '0, in_az = '0;
  logic signed [CRD_W-1:0] in_bx = '0, in_by = '0, in_bz = '0;
  logic signed [CRD_W-1:0] in_cx = '0, in_cy = '0, in_cz = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [NRM_W-1:0] out_nx, out_ny, out_nz;
  logic out_degenerate;

  normal_t pending_normals[$];
  int      mismatches = 0;
  int      normals_seen = 0;
  int      degen_seen = 0;
  int      tris_sent = 0;
  bit      no_idle = 1'b0;   // set for a stretch with no gaps on either side

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  triangle_face_normal u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_ax(in_ax), .in_ay(in_ay), .in_az(in_az),
    .in_bx(in_bx), .in_by(in_by), .in_bz(in_bz),
    .in_cx(in_cx), .in_cy(in_cy), .in_cz(in_cz),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_nx(out_nx), .out_ny(out_ny), .out_nz(out_nz),
    .out_degenerate(out_degenerate)
  );

  // round(m * 2^NFB / sqrt(s)), bit by bit on the doubled ratio, tie away from zero
  function automatic logic [63:0] unit_component(logic [63:0] m, logic [63:0] s);
    logic [127:0] rhs, lhs;
    logic [63:0]  r, t;
    int           top;
    r   = '0;
    rhs = 128'(m) * 128'(m);
    rhs = rhs << (2 * NFB + 2);
    top = (NFB + 1 > 31) ? 31 : NFB + 1;
    for (int k = top; k >= 0; k--) begin
      t   = r | (64'd1 << k);
      lhs = 128'(t) * 128'(t) * 128'(s);
      if (lhs <= rhs) r = t;
    end
    return (r + 64'd1) >> 1;
  endfunction

  // exact cross product (c-b) x (b-a), reduced to 31 bits, then normalized
  function automatic normal_t face_normal(tri_t t);
    logic signed [EDGE_W-1:0]  e1 [3], e2 [3];
    logic signed [CROSS_W-1:0] cr [3];
    logic [CROSS_W-1:0]        mg [3];
    logic [CROSS_W-1:0]        top_mag;
    logic [63:0]               sum, q;
    int                        sh;
    normal_t                   res;
    for (int i = 0; i < 3; i++) begin
      e1[i] = t.c[i] - t.b[i];
      e2[i] = t.b[i] - t.a[i];
    end
    cr[0] = e1[1] * e2[2] - e1[2] * e2[1];
    cr[1] = e1[2] * e2[0] - e1[0] * e2[2];
    cr[2] = e1[0] * e2[1] - e1[1] * e2[0];
    top_mag = '0;
    for (int i = 0; i < 3; i++) begin
      mg[i] = cr[i] < 0 ? -cr[i] : cr[i];
      if (mg[i] > top_mag) top_mag = mg[i];
    end
    res.degen = (top_mag == 0);
    for (int i = 0; i < 3; i++) res.n[i] = '0;
    if (res.degen) return res;
    sh = 0;
    while (top_mag[CROSS_W-1:31] != 0) begin
      top_mag = top_mag >> 1;
      sh++;
    end
    sum = '0;
    for (int i = 0; i < 3; i++) begin
      mg[i] = mg[i] >> sh;
      sum  += 64'(mg[i]) * 64'(mg[i]);
    end
    for (int i = 0; i < 3; i++) begin
      q = unit_component(64'(mg[i]), sum);
      if (q > 64'd32767) q = 64'd32767;
      res.n[i] = (cr[i] < 0) ? -NRM_W'(q) : NRM_W'(q);
    end
    return res;
  endfunction

  function automatic bit gap_now();
    return !no_idle && ($urandom_range(99) < 13);
  endfunction

  // Send one triangle; valid stays high into the next call unless a gap follows.
  task automatic send_tri(tri_t t);
    while (gap_now()) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_ax <= t.a[0]; in_ay <= t.a[1]; in_az <= t.a[2];
    in_bx <= t.b[0]; in_by <= t.b[1]; in_bz <= t.b[2];
    in_cx <= t.c[0]; in_cy <= t.c[1]; in_cz <= t.c[2];
    do @(posedge clk); while (in_stall);
    pending_normals.push_back(face_normal(t));
    tris_sent++;
  endtask

  task automatic wait_drained();
    while (pending_normals.size() != 0) @(posedge clk);
  endtask

  function automatic tri_t make_tri(int ax, int ay, int az, int bx, int by, int bz,
                                    int cx, int cy, int cz);
    tri_t t;
    t.a = '{ax, ay, az};
    t.b = '{bx, by, bz};
    t.c = '{cx, cy, cz};
    return t;
  endfunction

  // coordinate drawn from a mix of ranges so that all bits toggle
  function automatic logic signed [CRD_W-1:0] rand_coord(int mode);
    case (mode)
      0: return $urandom();
      1: return $signed($urandom_range(131072)) - 65536;
      2: return $signed($urandom_range(8)) - 4;
      default: begin
        case ($urandom_range(3))
          0: return 32'sh7fffffff;
          1: return 32'sh80000000;
          2: return 0;
          default: return $urandom();
        endcase
      end
    endcase
  endfunction

  function automatic tri_t rand_tri();
    tri_t t;
    int   mode, kind;
    mode = $urandom_range(3);
    for (int i = 0; i < 3; i++) begin
      t.a[i] = rand_coord(mode);
      t.b[i] = rand_coord(mode);
      t.c[i] = rand_coord(mode);
    end
    kind = $urandom_range(9);
    if (kind == 0) begin
      // collinear: c - b is a multiple of b - a
      for (int i = 0; i < 3; i++) begin
        t.a[i] = rand_coord(2) * 1000;
        t.b[i] = t.a[i] + rand_coord(2);
      end
      for (int i = 0; i < 3; i++) t.c[i] = t.b[i] + 3 * (t.b[i] - t.a[i]);
    end else if (kind == 1) begin
      t.b = t.a;  // two vertices coincide
    end else if (kind == 2) begin
      // triangle parallel to the xy plane, the x and y components of the normal vanish
      t.a[2] = t.b[2];
      t.c[2] = t.b[2];
    end
    return t;
  endfunction

  // Result checker: compare each transfer with the oldest prediction.
  always @(posedge clk) begin
    normal_t want;
    if (rst_n && out_valid && !out_stall) begin
      normals_seen++;
      if (out_degenerate) degen_seen++;
      if (pending_normals.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected normal %0d %0d %0d deg %0b",
                                       out_nx, out_ny, out_nz, out_degenerate);
      end else begin
        want = pending_normals.pop_front();
        if (out_nx !== want.n[0] || out_ny !== want.n[1] || out_nz !== want.n[2] ||
            out_degenerate !== want.degen) begin
          mismatches++;
          if (mismatches <= 10)
            $display("normal mismatch: exp %0d %0d %0d deg %0b, got %0d %0d %0d deg %0b",
                     want.n[0], want.n[1], want.n[2], want.degen,
                     out_nx, out_ny, out_nz, out_degenerate);
        end
      end
    end
  end

  // Receiver back-pressure.
  always @(posedge clk) begin
    out_stall <= gap_now();
  end

  // Extremes, degenerate shapes, axis normals, sign of each component.
  task automatic test_directed();
    int mx, mn;
    mx = 32'sh7fffffff;
    mn = 32'sh80000000;
    send_tri(make_tri(0, 0, 0, 0, 0, 0, 0, 0, 0));          // all zero
    send_tri(make_tri(5, 6, 7, 5, 6, 7, 5, 6, 7));          // one point
    send_tri(make_tri(0, 0, 0, 65536, 0, 0, 131072, 0, 0)); // collinear
    send_tri(make_tri(0, 0, 0, 65536, 0, 0, 0, 65536, 0));  // against z
    send_tri(make_tri(0, 0, 0, 0, 65536, 0, 65536, 0, 0));  // along z
    send_tri(make_tri(0, 0, 0, 0, 65536, 0, 0, 0, 65536));
    send_tri(make_tri(0, 0, 0, 0, 0, 65536, 0, 65536, 0));
    send_tri(make_tri(0, 0, 0, 0, 0, 65536, 65536, 0, 0));
    send_tri(make_tri(0, 0, 0, 65536, 0, 0, 0, 0, 65536));
    send_tri(make_tri(0, 0, 0, 1, 0, 0, 0, 1, 0));          // smallest area
    send_tri(make_tri(65536, 0, 0, 0, 65536, 0, 0, 0, 65536)); // diagonal
    send_tri(make_tri(mn, mn, mn, mx, mn, mn, mn, mx, mn)); // largest edges
    send_tri(make_tri(mn, mn, mn, mx, mx, mn, mn, mx, mx));
    send_tri(make_tri(mx, mx, mx, mn, mn, mn, mx, mn, mx));
    send_tri(make_tri(mn, 0, mx, mx, mn, 0, 0, mx, mn));
    send_tri(make_tri(mx, mx, mx, mx, mx, mx, mn, mn, mn)); // extremes, degenerate
    send_tri(make_tri(mn, mx, mn, mx, mn, mx, mn, mx, mn)); // back and forth
    send_tri(make_tri(0, 0, 0, 3, 4, 0, 0, 0, 1));          // exact 3-4-5 ratios
    send_tri(make_tri(0, 0, 0, 1, 1000000, 0, 0, 0, 1));   // one tiny component
    send_tri(make_tri(-7, 9, -11, 13, -17, 19, -23, 29, -31));
  endtask

  task automatic test_random(int count);
    for (int i = 0; i < count; i++) send_tri(rand_tri());
  endtask

  // Back-to-back transfers, no gaps on either side.
  task automatic test_full_rate(int count);
    no_idle = 1'b1;
    test_random(count);
    no_idle = 1'b0;
  endtask

  // Sender holds off until the pipeline is empty, then resumes.
  task automatic test_drain_restart(int count);
    in_valid <= 1'b0;
    wait_drained();
    test_random(count);
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(400);
    test_full_rate(250);
    test_drain_restart(20);
    test_random(380);
    in_valid <= 1'b0;
    wait_drained();
    repeat (LAT) @(posedge clk);
    $display("Sent %0d triangles, checked %0d normals (%0d degenerate).",
             tris_sent, normals_seen, degen_seen);
    $display("Covered extreme coordinates, degenerate shapes, stalls and full-rate bursts.");
    if (mismatches == 0 && pending_normals.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("%0d mismatches, %0d normals missing", mismatches, pending_normals.size());
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("timeout");
    $display("FAILED: results differ");
    $finish;
  end

endmodule
